/* src/dhm_pkg.sv */
// shared constants, types and codes of the double hash map
`timescale 1ns / 1ps
package dhm_pkg;

	localparam int TABLE_SIZE = 1024;
	localparam int IDX_BITS   = $clog2(TABLE_SIZE);
	localparam int MARK_BITS  = 16;
	localparam int KEY_BITS   = 31;
	localparam int VAL_BITS   = 31;
	localparam int COUNT_BITS = 11;
	localparam int STEP_MOD   = TABLE_SIZE - 13;
	// 2^IDX_BITS mod STEP_MOD, the weight of the high part in one fold
	localparam int FOLD_MUL   = TABLE_SIZE % STEP_MOD;
	// folds that bring a 31-bit key below twice STEP_MOD
	localparam int FOLDS      = 4;
	localparam int FOLD_CNT_BITS = $clog2(FOLDS);

	localparam int PADDR_BITS = 3;
	localparam int PDATA_BITS = 32;
	localparam logic [PADDR_BITS-3:0] REG_LOAD_LIMIT = '0;
	localparam logic [COUNT_BITS-1:0] LOAD_LIMIT_RESET = COUNT_BITS'(921);

	typedef enum logic [1:0] {
		ACT_LOOKUP = 2'd0,
		ACT_INSERT = 2'd1,
		ACT_RESET  = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_MISS = 2'd1,
		ST_DUP  = 2'd2,
		ST_FULL = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_CLR_INIT,
		S_IDLE,
		S_FOLD,
		S_STEP,
		S_READ,
		S_CHECK,
		S_CLR_WRAP,
		S_RESP
	} state_t;

	typedef struct packed {
		logic [1:0]          action;
		logic [KEY_BITS-1:0] key;
		logic [VAL_BITS-1:0] value;
	} req_t;

	typedef struct packed {
		status_t             status;
		logic [VAL_BITS-1:0] found_value;
	} rsp_t;

	typedef struct packed {
		logic [KEY_BITS-1:0]  key;
		logic [VAL_BITS-1:0]  value;
		logic [MARK_BITS-1:0] mark;
	} slot_t;

	typedef struct packed {
		logic    load_req;
		logic    fold;
		logic    init_probe;
		logic    rd_en;
		logic    advance;
		logic    write_slot;
		logic    clear_wr;
		logic    gen_adv;
		logic    count_clr;
		logic    count_inc;
		logic    load_rsp;
		status_t rsp_status;
		logic    rsp_take_data;
	} dhm_cmd_t;

	typedef struct packed {
		logic count_full;
		logic gen_wrap;
		logic live;
		logic key_eq;
		logic probe_last;
		logic clear_last;
	} dhm_sts_t;

endpackage

/* src/dhm_regs.sv */
// configuration register file behind the apb port
`timescale 1ns / 1ps
module dhm_regs
	import dhm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [PADDR_BITS-1:0] paddr,
	input  logic [PDATA_BITS-1:0] pwdata,
	output logic [PDATA_BITS-1:0] prdata,
	output logic                  pready,
	output logic [COUNT_BITS-1:0] load_limit
);

	logic [COUNT_BITS-1:0] load_limit_q;
	logic [PADDR_BITS-3:0] reg_idx;

	// byte offset bits do not select a register
	assign reg_idx = paddr[PADDR_BITS-1:2];
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_limit_q <= LOAD_LIMIT_RESET;
		end else if (psel && penable && pwrite && pready && reg_idx == REG_LOAD_LIMIT) begin
			load_limit_q <= pwdata[COUNT_BITS-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_idx == REG_LOAD_LIMIT) begin
			prdata = PDATA_BITS'(load_limit_q);
		end
	end

	assign load_limit = load_limit_q;

endmodule

/* src/dhm_dp.sv */
// datapath: step hash, probe walk, slot memory, generation and count
`timescale 1ns / 1ps
module dhm_dp
	import dhm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  req_t                  req,
	input  logic [COUNT_BITS-1:0] load_limit,
	input  dhm_cmd_t              cmd,
	output dhm_sts_t              sts,
	output rsp_t                  rsp
);

	logic [KEY_BITS-1:0]   key_q;
	logic [VAL_BITS-1:0]   value_q;
	logic [KEY_BITS-1:0]   rem_q;
	logic [IDX_BITS-1:0]   idx_q;
	logic [IDX_BITS-1:0]   step_q;
	logic [IDX_BITS-1:0]   probe_cnt_q;
	logic [IDX_BITS-1:0]   clr_addr_q;
	logic [MARK_BITS-1:0]  gen_q;
	logic [COUNT_BITS-1:0] count_q;
	slot_t                 slot_mem_q [TABLE_SIZE];
	slot_t                 rd_q;
	rsp_t                  rsp_q;

	logic [KEY_BITS-1:0]   fold_sum;
	logic [KEY_BITS-1:0]   rem_red;
	logic [MARK_BITS-1:0]  gen_inc;
	logic [IDX_BITS-1:0]   idx_next;
	logic [IDX_BITS-1:0]   rd_addr;
	logic [IDX_BITS-1:0]   wr_addr;
	logic                  wr_en;
	slot_t                 wr_data;

	// x = hi * 2^IDX_BITS + lo is congruent to hi * FOLD_MUL + lo
	assign fold_sum = KEY_BITS'(rem_q[KEY_BITS-1:IDX_BITS] * FOLD_MUL)
		+ KEY_BITS'(rem_q[IDX_BITS-1:0]);
	assign rem_red  = (rem_q >= KEY_BITS'(STEP_MOD)) ? rem_q - KEY_BITS'(STEP_MOD) : rem_q;

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			key_q   <= req.key;
			value_q <= req.value;
			rem_q   <= req.key;
		end else if (cmd.fold) begin
			rem_q <= fold_sum;
		end
	end

	// an even step is raised by one, which is the same as setting bit zero
	assign idx_next = idx_q + step_q;

	always_ff @(posedge clk) begin
		if (cmd.init_probe) begin
			idx_q       <= key_q[IDX_BITS-1:0];
			step_q      <= rem_red[IDX_BITS-1:0] | IDX_BITS'(1);
			probe_cnt_q <= '0;
		end else if (cmd.advance) begin
			idx_q       <= idx_next;
			probe_cnt_q <= probe_cnt_q + IDX_BITS'(1);
		end
	end

	assign gen_inc = gen_q + MARK_BITS'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_q      <= MARK_BITS'(1);
			count_q    <= '0;
			clr_addr_q <= '0;
		end else begin
			if (cmd.gen_adv) begin
				gen_q <= (gen_inc == '0) ? MARK_BITS'(1) : gen_inc;
			end
			if (cmd.count_clr) begin
				count_q <= '0;
			end else if (cmd.count_inc) begin
				count_q <= count_q + COUNT_BITS'(1);
			end
			if (cmd.clear_wr) begin
				clr_addr_q <= clr_addr_q + IDX_BITS'(1);
			end
		end
	end

	assign rd_addr = cmd.advance ? idx_next : idx_q;
	assign wr_en   = cmd.clear_wr || cmd.write_slot;
	assign wr_addr = cmd.clear_wr ? clr_addr_q : idx_q;

	always_comb begin
		wr_data.key   = key_q;
		wr_data.value = value_q;
		wr_data.mark  = cmd.clear_wr ? '0 : gen_q;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_mem_q[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rd_q <= slot_mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_rsp) begin
			rsp_q.status      <= cmd.rsp_status;
			rsp_q.found_value <= cmd.rsp_take_data ? rd_q.value : '0;
		end
	end

	assign rsp = rsp_q;

	always_comb begin
		sts.count_full = count_q >= load_limit;
		sts.gen_wrap   = gen_inc == '0;
		sts.live       = rd_q.mark == gen_q;
		sts.key_eq     = rd_q.key == key_q;
		sts.probe_last = &probe_cnt_q;
		sts.clear_last = &clr_addr_q;
	end

endmodule

/* src/dhm_ctrl.sv */
// controller: sequences hashing, probing, clearing and the result transaction
`timescale 1ns / 1ps
module dhm_ctrl
	import dhm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_stall,
	input  logic [1:0] req_action,
	output logic       rsp_valid,
	input  logic       rsp_stall,
	input  dhm_sts_t   sts,
	output dhm_cmd_t   cmd
);

	state_t                   state_q, state_d;
	logic [FOLD_CNT_BITS-1:0] fold_cnt_q, fold_cnt_d;
	logic [1:0]               act_q, act_d;
	status_t                  res_status_q, res_status_d;
	logic                     res_data_q, res_data_d;
	logic                     rsp_valid_q, rsp_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLR_INIT;
			fold_cnt_q   <= '0;
			act_q        <= '0;
			res_status_q <= ST_OK;
			res_data_q   <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			fold_cnt_q   <= fold_cnt_d;
			act_q        <= act_d;
			res_status_q <= res_status_d;
			res_data_q   <= res_data_d;
			rsp_valid_q  <= rsp_valid_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		fold_cnt_d   = fold_cnt_q;
		act_d        = act_q;
		res_status_d = res_status_q;
		res_data_d   = res_data_q;
		cmd          = '0;
		cmd.rsp_status    = res_status_q;
		cmd.rsp_take_data = res_data_q;
		req_stall    = 1'b1;

		unique case (state_q)
			S_CLR_INIT: begin
				cmd.clear_wr = 1'b1;
				if (sts.clear_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					cmd.load_req = 1'b1;
					act_d        = req_action;
					res_status_d = ST_OK;
					res_data_d   = 1'b0;
					fold_cnt_d   = '0;
					case (req_action)
						ACT_LOOKUP: begin
							state_d = S_FOLD;
						end
						ACT_INSERT: begin
							if (sts.count_full) begin
								res_status_d = ST_FULL;
								state_d      = S_RESP;
							end else begin
								state_d = S_FOLD;
							end
						end
						ACT_RESET: begin
							cmd.gen_adv   = 1'b1;
							cmd.count_clr = 1'b1;
							state_d = sts.gen_wrap ? S_CLR_WRAP : S_RESP;
						end
						default: begin
							state_d = S_RESP;
						end
					endcase
				end
			end
			S_FOLD: begin
				cmd.fold   = 1'b1;
				fold_cnt_d = fold_cnt_q + FOLD_CNT_BITS'(1);
				if (fold_cnt_q == FOLD_CNT_BITS'(FOLDS - 1)) begin
					state_d = S_STEP;
				end
			end
			S_STEP: begin
				cmd.init_probe = 1'b1;
				state_d        = S_READ;
			end
			S_READ: begin
				cmd.rd_en = 1'b1;
				state_d   = S_CHECK;
			end
			S_CHECK: begin
				if (act_q == ACT_INSERT) begin
					if (!sts.live) begin
						cmd.write_slot = 1'b1;
						cmd.count_inc  = 1'b1;
						res_status_d   = ST_OK;
						state_d        = S_RESP;
					end else if (sts.key_eq) begin
						res_status_d = ST_DUP;
						state_d      = S_RESP;
					end else if (sts.probe_last) begin
						res_status_d = ST_FULL;
						state_d      = S_RESP;
					end else begin
						cmd.advance = 1'b1;
						cmd.rd_en   = 1'b1;
					end
				end else begin
					if (sts.live && sts.key_eq) begin
						res_status_d = ST_OK;
						res_data_d   = 1'b1;
						state_d      = S_RESP;
					end else if (!sts.live || sts.probe_last) begin
						res_status_d = ST_MISS;
						state_d      = S_RESP;
					end else begin
						cmd.advance = 1'b1;
						cmd.rd_en   = 1'b1;
					end
				end
			end
			S_CLR_WRAP: begin
				cmd.clear_wr = 1'b1;
				if (sts.clear_last) begin
					state_d = S_RESP;
				end
			end
			S_RESP: begin
				if (!rsp_valid_q || !rsp_stall) begin
					cmd.load_rsp = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		rsp_valid_d = rsp_valid_q;
		if (cmd.load_rsp) begin
			rsp_valid_d = 1'b1;
		end else if (rsp_valid_q && !rsp_stall) begin
			rsp_valid_d = 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;

endmodule

/* src/double_hash_map_generation_clear.sv */
// Key to value map in a 1024-slot table probed by double hashing. For lookup and insert
// the key is folded four times into its probe step, then the slot memory is read once
// per probe with its data registered. Reset actions, unused actions and inserts refused
// for load skip the hashing and probing. After reset, and after a reset action that wraps
// the generation, a clearing pass writes every slot mark, one slot a cycle, while no
// request is taken; apb writes are taken at any time. One result buffer lets the next
// request enter while the previous result is still stalled.
`timescale 1ns / 1ps
module double_hash_map_generation_clear
	import dhm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  req_t                  req,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output rsp_t                  rsp,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [PADDR_BITS-1:0] paddr,
	input  logic [PDATA_BITS-1:0] pwdata,
	output logic [PDATA_BITS-1:0] prdata,
	output logic                  pready
);

	logic [COUNT_BITS-1:0] load_limit;
	dhm_cmd_t              cmd;
	dhm_sts_t              sts;

	dhm_regs u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.load_limit (load_limit)
	);

	dhm_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req_action (req.action),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	dhm_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.load_limit (load_limit),
		.cmd        (cmd),
		.sts        (sts),
		.rsp        (rsp)
	);

endmodule

/* src/dhm_chk.sv */
// port-level checker for the double hash map and its bind
`timescale 1ns / 1ps
module dhm_chk
	import dhm_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  req_valid,
	input logic                  req_stall,
	input req_t                  req,
	input logic                  rsp_valid,
	input logic                  rsp_stall,
	input rsp_t                  rsp,
	input logic                  psel,
	input logic                  penable,
	input logic                  pwrite,
	input logic [PADDR_BITS-1:0] paddr,
	input logic [PDATA_BITS-1:0] pwdata,
	input logic [PDATA_BITS-1:0] prdata,
	input logic                  pready
);

	// a stalled result transaction holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled result changed or dropped");

	// data only comes with a successful lookup
	a_data_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.found_value != '0 |-> rsp.status == ST_OK)
		else $error("found_value nonzero on a non-ok result");

	// one request at a time: busy right after a request transaction
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken while the previous one is at work");

	// load limit reads back what was just written
	a_limit_rb: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && pready && !paddr[2])
		##1 (psel && penable && !pwrite && !paddr[2])
		|-> prdata == {{(PDATA_BITS-COUNT_BITS){1'b0}}, $past(pwdata[COUNT_BITS-1:0])})
		else $error("load limit read back mismatch");

endmodule

bind double_hash_map_generation_clear dhm_chk u_chk (.*);
